@@ rtl/core/sca_pkg.sv @@
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types and constants for the stack calculator ALU core: opcodes,
// status codes, sequencer states and field widths.
// ----------------------------------------------------------------------------
package sca_pkg;

  localparam int WORD_W          = 32;
  localparam int DEPTH_W         = 5;
  localparam int OP_W            = 3;
  localparam int STATUS_W        = 2;
  localparam int ITER_W          = $clog2(WORD_W);
  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(WORD_W - 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_ADD   = 3'd3,
    OP_SUB   = 3'd4,
    OP_MUL   = 3'd5,
    OP_DIV   = 3'd6,
    OP_CLEAR = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_READ2,
    S_ADD,
    S_SUB,
    S_MUL,
    S_NEG_N,
    S_NEG_D,
    S_DIV,
    S_SIGN,
    S_DONE
  } state_t;

endpackage

@@ rtl/core/stack_calculator_alu_core.sv @@
// One 33-bit add/sub unit does all arithmetic, one bit per cycle for mul and
// div. An item is accepted only when the sequencer is idle, so a new item is
// not taken until the previous one has committed its result.
// Reset (rst, synchronous) empties the stack and drops any pending result;
// stack contents are not cleared.
// ----------------------------------------------------------------------------
// stack_calculator_alu_core
// RPN calculator stack of signed 32-bit words. Stack words live in a
// single-port-write, registered-read memory; all arithmetic runs through one
// shared adder/subtractor under a small sequencer.
// ----------------------------------------------------------------------------
module stack_calculator_alu_core
  import sca_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [OP_W-1:0]           opcode,
  input  logic signed [WORD_W-1:0]  push_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [WORD_W-1:0]  result_value,
  output logic [DEPTH_W-1:0]        depth,
  output logic                      stack_empty,
  output logic [STATUS_W-1:0]       status
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] TWO  = CW'(2);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  state_t            state, state_next;
  op_t               op, op_next;
  status_t           stat, stat_next;
  logic [WORD_W-1:0] push_val, val_next;
  logic [WORD_W-1:0] top_w, top_next;
  logic [WORD_W-1:0] second_w, second_next;
  logic [WORD_W-1:0] acc, acc_next;
  logic [WORD_W-1:0] rem, rem_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic              neg_q, neg_next;
  logic [CW-1:0]     word_count, count_next;
  logic              commit;

  logic [CW-1:0]     count_m1, count_m2;
  logic [AW-1:0]     top_addr, second_addr;
  logic [WORD_W:0]   rem_sh;
  logic              q_bit;

  // shared arithmetic unit
  logic [WORD_W:0]   alu_a, alu_b;
  logic              alu_sub;
  logic [WORD_W+1:0] alu_sum;

  assign alu_sum = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});

  assign count_m1    = word_count - ONE;
  assign count_m2    = word_count - TWO;
  assign top_addr    = count_m1[AW-1:0];
  assign second_addr = count_m2[AW-1:0];
  assign rem_sh      = {rem, top_w[WORD_W-1]};

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      word_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      word_count <= count_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    stat     <= stat_next;
    push_val <= val_next;
    top_w    <= top_next;
    second_w <= second_next;
    acc      <= acc_next;
    rem      <= rem_next;
    iter     <= iter_next;
    neg_q    <= neg_next;
    if (commit) begin
      result_value <= acc;
      depth        <= DEPTH_W'(count_next);
      stack_empty  <= (count_next == '0);
      status       <= stat;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next  = state;
    op_next     = op;
    stat_next   = stat;
    val_next    = push_val;
    top_next    = top_w;
    second_next = second_w;
    acc_next    = acc;
    rem_next    = rem;
    iter_next   = iter;
    neg_next    = neg_q;
    count_next  = word_count;
    commit      = 1'b0;
    rd_addr     = top_addr;
    wr_en       = 1'b0;
    wr_addr     = word_count[AW-1:0];
    wr_data     = push_val;
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;
    q_bit       = 1'b0;

    case (state)
      S_IDLE: begin
        // top word read is issued on the accept edge
        if (in_valid) begin
          op_next    = op_t'(opcode);
          val_next   = push_value;
          state_next = S_CHECK;
        end
      end

      S_CHECK: begin
        stat_next  = ST_OK;
        acc_next   = '0;
        rd_addr    = second_addr;
        state_next = S_DONE;
        case (op)
          OP_PUSH: begin
            if (word_count >= FULL) begin
              stat_next = ST_OVER;
            end
          end
          OP_POP, OP_PEEK: begin
            if (word_count == '0) begin
              stat_next = ST_UNDER;
            end else begin
              acc_next = rd_data;
            end
          end
          OP_CLEAR: begin
            stat_next = ST_OK;
          end
          default: begin
            if (word_count < TWO) begin
              stat_next = ST_UNDER;
            end else begin
              top_next   = rd_data;
              state_next = S_READ2;
            end
          end
        endcase
      end

      S_READ2: begin
        second_next = rd_data;
        iter_next   = '0;
        rem_next    = '0;
        case (op)
          OP_ADD:  state_next = S_ADD;
          OP_SUB:  state_next = S_SUB;
          OP_MUL:  state_next = S_MUL;
          default: begin
            if (rd_data == '0) begin
              stat_next  = ST_DIVZ;
              state_next = S_DONE;
            end else begin
              state_next = S_NEG_N;
            end
          end
        endcase
      end

      S_ADD: begin
        alu_a      = {1'b0, second_w};
        alu_b      = {1'b0, top_w};
        acc_next   = alu_sum[WORD_W-1:0];
        state_next = S_DONE;
      end

      S_SUB: begin
        alu_a      = {1'b0, second_w};
        alu_b      = {1'b0, top_w};
        alu_sub    = 1'b1;
        acc_next   = alu_sum[WORD_W-1:0];
        state_next = S_DONE;
      end

      S_MUL: begin
        // shift-add: only the low word of the product is kept
        alu_a       = {1'b0, acc};
        alu_b       = second_w[0] ? {1'b0, top_w} : '0;
        acc_next    = alu_sum[WORD_W-1:0];
        top_next    = {top_w[WORD_W-2:0], 1'b0};
        second_next = {1'b0, second_w[WORD_W-1:1]};
        iter_next   = iter + ITER_W'(1);
        if (iter == ITER_LAST) begin
          state_next = S_DONE;
        end
      end

      S_NEG_N: begin
        alu_b    = {1'b0, top_w};
        alu_sub  = 1'b1;
        neg_next = top_w[WORD_W-1] ^ second_w[WORD_W-1];
        if (top_w[WORD_W-1]) begin
          top_next = alu_sum[WORD_W-1:0];
        end
        state_next = S_NEG_D;
      end

      S_NEG_D: begin
        alu_b   = {1'b0, second_w};
        alu_sub = 1'b1;
        if (second_w[WORD_W-1]) begin
          second_next = alu_sum[WORD_W-1:0];
        end
        state_next = S_DIV;
      end

      S_DIV: begin
        // restoring step: dividend bits shift out of top_w, quotient bits in
        alu_a   = rem_sh;
        alu_b   = {1'b0, second_w};
        alu_sub = 1'b1;
        if (!alu_sum[WORD_W+1]) begin
          rem_next = alu_sum[WORD_W-1:0];
          q_bit    = 1'b1;
        end else begin
          rem_next = rem_sh[WORD_W-1:0];
        end
        top_next  = {top_w[WORD_W-2:0], q_bit};
        iter_next = iter + ITER_W'(1);
        if (iter == ITER_LAST) begin
          state_next = S_SIGN;
        end
      end

      S_SIGN: begin
        alu_b      = {1'b0, top_w};
        alu_sub    = 1'b1;
        acc_next   = neg_q ? alu_sum[WORD_W-1:0] : top_w;
        state_next = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free, then commit stack changes
        if (!out_valid || !out_stall) begin
          commit     = 1'b1;
          state_next = S_IDLE;
          if (stat == ST_OK) begin
            case (op)
              OP_PUSH: begin
                wr_en      = 1'b1;
                count_next = word_count + ONE;
              end
              OP_POP:   count_next = count_m1;
              OP_PEEK:  count_next = word_count;
              OP_CLEAR: count_next = '0;
              default: begin
                wr_en      = 1'b1;
                wr_addr    = second_addr;
                wr_data    = acc;
                count_next = count_m1;
              end
            endcase
          end else if (stat == ST_DIVZ) begin
            count_next = count_m2;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/sca_checker.sv @@
// ----------------------------------------------------------------------------
// sca_checker
// Port-level checks for the stack calculator ALU core, bound to the top level.
// ----------------------------------------------------------------------------
module sca_checker
  import sca_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [WORD_W-1:0] result_value,
  input logic [DEPTH_W-1:0]       depth,
  input logic                     stack_empty,
  input logic [STATUS_W-1:0]      status
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(status))
    else $error("stalled result beat changed");

  // an accepted beat makes the input side busy in the cycle after
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> result_value == '0)
    else $error("error result carries nonzero value");

  a_empty_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && (depth != '0) |-> !stack_empty)
    else $error("empty flag set with nonzero depth");

endmodule

bind stack_calculator_alu_core sca_checker u_sca_checker (.*);

@@ bench/stack_calculator_alu_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_calculator_alu_core_test
// Self-checking bench for the RPN stack calculator core. A directed opening
// covers the underflow, overflow, wrap and divide cases. Random expression
// runs, fill-to-overflow bursts, clears and noise follow, with random idling
// and back-pressure on both channels. A shadow stack predicts every result
// beat, and the scoreboard compares it field by field.
// ----------------------------------------------------------------------------
import sca_pkg::*;

typedef struct {
  logic [WORD_W-1:0]   value;
  logic [DEPTH_W-1:0]  depth;
  logic                empty;
  status_t             status;
} rpn_result_t;

class rpn_tracker;
  logic [WORD_W-1:0] words [STACK_DEPTH_DEF];
  int unsigned       count;
  rpn_result_t       expected_results [$];
  int unsigned       failures;
  int unsigned       matched;
  int unsigned       status_seen [4];
  int unsigned       op_seen [8];

  function new();
    count    = 0;
    failures = 0;
    matched  = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
  endfunction

  // Truncating signed divide done on magnitudes; wraps for min / -1.
  function logic [WORD_W-1:0] quotient(logic [WORD_W-1:0] num, logic [WORD_W-1:0] den);
    logic [WORD_W-1:0] nm;
    logic [WORD_W-1:0] dm;
    logic [WORD_W-1:0] q;
    nm = num[WORD_W-1] ? (32'd0 - num) : num;
    dm = den[WORD_W-1] ? (32'd0 - den) : den;
    q  = nm / dm;
    return (num[WORD_W-1] != den[WORD_W-1]) ? (32'd0 - q) : q;
  endfunction

  function void note_beat(op_t op, logic [WORD_W-1:0] val);
    rpn_result_t       r;
    logic [WORD_W-1:0] top;
    logic [WORD_W-1:0] second;
    logic [WORD_W-1:0] res;
    status_t           st;
    res = '0;
    st  = ST_OK;
    op_seen[op]++;
    case (op)
      OP_PUSH: begin
        if (count >= STACK_DEPTH_DEF) begin
          st = ST_OVER;
        end else begin
          words[count] = val;
          count++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (count == 0) begin
          st = ST_UNDER;
        end else begin
          res = words[count-1];
          if (op == OP_POP) count--;
        end
      end
      OP_CLEAR: count = 0;
      default: begin
        if (count < 2) begin
          st = ST_UNDER;
        end else begin
          top    = words[count-1];
          second = words[count-2];
          count  = count - 2;
          case (op)
            OP_ADD: res = second + top;
            OP_SUB: res = second - top;
            OP_MUL: res = second * top;
            default: begin
              if (second == '0) st = ST_DIVZ;
              else res = quotient(top, second);
            end
          endcase
          if (st == ST_OK) begin
            words[count] = res;
            count++;
          end
        end
      end
    endcase
    r.value  = res;
    r.depth  = count[DEPTH_W-1:0];
    r.empty  = (count == 0);
    r.status = st;
    expected_results.push_back(r);
  endfunction

  function void check_beat(logic [WORD_W-1:0] value, logic [DEPTH_W-1:0] d, logic e,
                           logic [STATUS_W-1:0] s);
    rpn_result_t exp_r;
    bit          bad;
    if (expected_results.size() == 0) begin
      failures++;
      $display("%0t: result beat with nothing expected: value %h depth %0d status %0d",
               $time, value, d, s);
      return;
    end
    exp_r = expected_results.pop_front();
    bad   = 0;
    if (value !== exp_r.value) begin
      bad = 1;
      $display("%0t: result_value expected %h actual %h", $time, exp_r.value, value);
    end
    if (d !== exp_r.depth) begin
      bad = 1;
      $display("%0t: depth expected %0d actual %0d", $time, exp_r.depth, d);
    end
    if (e !== exp_r.empty) begin
      bad = 1;
      $display("%0t: stack_empty expected %0d actual %0d", $time, exp_r.empty, e);
    end
    if (s !== exp_r.status) begin
      bad = 1;
      $display("%0t: status expected %0d actual %0d", $time, exp_r.status, s);
    end
    if (bad) failures++;
    else matched++;
    status_seen[exp_r.status]++;
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction
endclass

module stack_calculator_alu_core_test;
  localparam int                STACK_DEPTH = STACK_DEPTH_DEF;
  localparam int unsigned       NUM_ITEMS   = 1300;
  localparam int unsigned       LIMIT       = 500000;
  localparam logic [WORD_W-1:0] WORD_MAX    = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] WORD_MIN    = 32'h8000_0000;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [OP_W-1:0]            opcode;
  logic signed [WORD_W-1:0]   push_value;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [WORD_W-1:0]   result_value;
  logic [DEPTH_W-1:0]         depth;
  logic                       stack_empty;
  logic [STATUS_W-1:0]        status;

  rpn_tracker  tracker;
  int unsigned beats_sent = 0;
  int unsigned cycles     = 0;
  bit          calm       = 0;

  stack_calculator_alu_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .push_value  (push_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_value(result_value),
    .depth       (depth),
    .stack_empty (stack_empty),
    .status      (status)
  );

  initial clk = 0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, tracker.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_beat(result_value, depth, stack_empty, status);
  end

  // Receiver: random stalls, one long hold-off, no stalls in the calm window.
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 0;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && !hold_done && beats_sent >= 400) begin
        hold_left = 300;
        hold_done = 1;
      end
      if (hold_left != 0) begin
        out_stall = 1;
        hold_left--;
      end else if (calm || rst) begin
        out_stall = 0;
      end else begin
        out_stall = ($urandom_range(0, 99) < 29);
      end
    end
  end

  function automatic logic [WORD_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 15);
    case (r)
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return '1;
      4: return 32'd1;
      5, 6, 7: return 32'($urandom_range(0, 200)) - 32'd100;
      default: return $urandom();
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(op_t op, logic [WORD_W-1:0] val);
    if (!calm) begin
      while ($urandom_range(0, 99) < 29) begin
        in_valid = 0;
        @(negedge clk);
      end
    end
    in_valid   = 1;
    opcode     = op;
    push_value = val;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    tracker.note_beat(op, val);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic run_directed();
    send_beat(OP_POP, pick_value());    // underflow on empty
    send_beat(OP_PEEK, pick_value());   // underflow on empty
    send_beat(OP_ADD, pick_value());    // binary op with no words
    send_beat(OP_PUSH, WORD_MIN);
    send_beat(OP_SUB, pick_value());    // binary op with one word
    repeat (8) send_beat(OP_PUSH, pick_value());
    // Top of stack ends as MAX MAX MIN 1 0 -1 MIN; stack is then full.
    send_beat(OP_PUSH, WORD_MAX);
    send_beat(OP_PUSH, WORD_MAX);
    send_beat(OP_PUSH, WORD_MIN);
    send_beat(OP_PUSH, 32'd1);
    send_beat(OP_PUSH, 32'd0);
    send_beat(OP_PUSH, '1);
    send_beat(OP_PUSH, WORD_MIN);
    send_beat(OP_PUSH, WORD_MAX);       // overflow
    send_beat(OP_DIV, pick_value());    // min / -1 wraps
    send_beat(OP_DIV, pick_value());    // zero divisor drops both
    send_beat(OP_SUB, pick_value());    // min - 1 wraps
    send_beat(OP_MUL, pick_value());    // max * max
    send_beat(OP_ADD, pick_value());    // max + 1 wraps
    send_beat(OP_PEEK, pick_value());
    send_beat(OP_POP, pick_value());
    send_beat(OP_CLEAR, pick_value());
  endtask

  task automatic send_expression_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tracker.count < 2 || r < 40) begin
      send_beat(OP_PUSH, pick_value());
    end else begin
      r = $urandom_range(0, 99);
      if (r < 10)      send_beat(OP_POP, pick_value());
      else if (r < 18) send_beat(OP_PEEK, pick_value());
      else if (r < 36) send_beat(OP_ADD, pick_value());
      else if (r < 54) send_beat(OP_SUB, pick_value());
      else if (r < 72) send_beat(OP_MUL, pick_value());
      else             send_beat(OP_DIV, pick_value());
    end
  endtask

  task automatic run_random();
    int unsigned kind;
    bit          drained;
    drained = 0;
    while (beats_sent < NUM_ITEMS) begin
      calm = (beats_sent >= 600 && beats_sent < 800);
      if (!drained && beats_sent >= 900) begin
        // Pause the sender until every result is back.
        drained  = 1;
        in_valid = 0;
        while (tracker.pending() != 0) @(negedge clk);
      end
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        repeat (STACK_DEPTH - tracker.count + $urandom_range(1, 3))
          send_beat(OP_PUSH, pick_value());
      end else if (kind < 22) begin
        repeat ($urandom_range(1, 6)) send_beat(op_t'($urandom_range(0, 7)), $urandom());
      end else if (kind < 25) begin
        send_beat(OP_CLEAR, pick_value());
      end else begin
        repeat ($urandom_range(1, 8)) send_expression_step();
      end
    end
    calm = 0;
  endtask

  initial begin : main
    tracker    = new();
    rst        = 1;
    in_valid   = 0;
    opcode     = OP_CLEAR;
    push_value = '0;
    repeat (8) @(negedge clk);
    rst = 0;
    @(negedge clk);
    run_directed();
    run_random();
    in_valid = 0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("covered %0d beats, %0d matched: ok %0d, underflow %0d, overflow %0d, div0 %0d",
             beats_sent, tracker.matched, tracker.status_seen[ST_OK],
             tracker.status_seen[ST_UNDER], tracker.status_seen[ST_OVER],
             tracker.status_seen[ST_DIVZ]);
    $display("opcodes: push %0d pop %0d peek %0d add %0d sub %0d mul %0d div %0d clear %0d",
             tracker.op_seen[OP_PUSH], tracker.op_seen[OP_POP], tracker.op_seen[OP_PEEK],
             tracker.op_seen[OP_ADD], tracker.op_seen[OP_SUB], tracker.op_seen[OP_MUL],
             tracker.op_seen[OP_DIV], tracker.op_seen[OP_CLEAR]);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures, %0d results never arrived", tracker.failures,
               tracker.pending());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/sca_pkg.sv
rtl/core/stack_calculator_alu_core.sv
rtl/core/sca_checker.sv
bench/stack_calculator_alu_core_test.sv
